// ----- rtl/tpaf_pkg.sv -----
// ----------------------------------------------------------------------------
// tpaf_pkg
// types, widths and the cordic angle table of the three point arc fit
// ----------------------------------------------------------------------------
package tpaf_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SQS_W        = PROD_W - 1;
    localparam int DET_W        = PROD_W;
    localparam int ADET_W       = DET_W - 1;
    localparam int LO_W         = DIFF_W;
    localparam int HI_W         = SQS_W - LO_W;
    localparam int PPL_W        = DIFF_W + LO_W + 1;
    localparam int PPH_W        = DIFF_W + HI_W + 1;
    localparam int NX_W         = 76;
    localparam int NUM_W        = NX_W;
    localparam int DIV_W        = ADET_W + 1;
    localparam int U_W          = NUM_W + 1;
    localparam int WC_W         = U_W + 1;
    localparam int VEC_W        = 80;
    localparam int CEN_W        = 32;
    localparam int MAG_W        = CEN_W + 1;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int ROOT_W       = MAG_W;
    localparam int REM_W        = ROOT_W + 3;
    localparam int THR_W        = 48;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int Z_W          = 32;
    localparam int KEEP_W       = 31;
    localparam int CX_W         = KEEP_W + 3;
    localparam int NORM_STAGES  = $clog2(VEC_W);

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic signed [COORD_W-1:0] last_x;
        logic signed [COORD_W-1:0] last_y;
    } tpaf_req_t;

    typedef struct packed {
        logic                      arc_valid;
        logic signed [CEN_W-1:0]   center_x;
        logic signed [CEN_W-1:0]   center_y;
        logic        [CEN_W-1:0]   radius;
        logic        [ANGLE_BITS-1:0] start_angle;
        logic        [ANGLE_BITS-1:0] end_angle;
        logic                      saturated;
    } tpaf_res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [DIFF_W-1:0]  ax;
        logic signed [DIFF_W-1:0]  ay;
        logic signed [DIFF_W-1:0]  bx;
        logic signed [DIFF_W-1:0]  by;
        logic        [ADET_W-1:0]  adet;
        logic                      dneg;
        logic                      coll;
    } tpaf_side_t;

    typedef struct packed {
        logic signed [CEN_W-1:0] cx;
        logic signed [CEN_W-1:0] cy;
        logic                    sat;
        logic                    big;
        logic                    coll;
    } tpaf_post_t;

    function automatic logic [Z_W-1:0] atan_ang(input int unsigned i);
        logic [Z_W-1:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10680862;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41721;
            15:      a = 32'd20860;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2607;
            19:      a = 32'd1303;
            20:      a = 32'd651;
            21:      a = 32'd325;
            22:      a = 32'd162;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/three_point_arc_fit.sv -----
// ----------------------------------------------------------------------------
// three_point_arc_fit
// circumcircle and counter-clockwise arc through three points, fully pipelined
//
//   channel   signals                       direction  handshake
//   request   start, busy, request          in         start & !busy
//   result    done, result                  out        done, one cycle
//   config    cfg_valid, cfg_ready, cfg_data in        cfg_valid & cfg_ready
//
// one request per cycle; the pipeline depth is set by the one bit per stage
// divider (76 stages) and the two bit per stage square root (33 stages). busy
// stays low and there is no stall on either side.
// reset clears the valid line and loads the threshold with 1.
// ----------------------------------------------------------------------------
module three_point_arc_fit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tpaf_pkg::tpaf_req_t           request,
    output logic                          done,
    output tpaf_pkg::tpaf_res_t           result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpaf_pkg::THR_W-1:0]    cfg_data
);
    import tpaf_pkg::*;

    localparam int ST_DET  = 4;
    localparam int ST_DIV0 = 8;
    localparam int ST_UX   = ST_DIV0 + NUM_W + 1;
    localparam int ST_P1   = ST_UX + 1;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_P3   = ST_P2 + 1;
    localparam int ST_SQE  = ST_P3 + ROOT_W;
    localparam int LAT     = ST_SQE + 1;
    localparam int ST_NE   = ST_P1 + NORM_STAGES;
    localparam int ST_CI   = ST_NE + 1;
    localparam int ST_CE   = ST_CI + CORDIC_STEPS;
    localparam int ST_AR   = ST_CE + 1;
    localparam int ST_SEL  = ST_AR + 1;

    logic [THR_W-1:0]  thr_reg;
    logic [LAT-1:0]    vld_reg;
    logic              accept;

    tpaf_side_t                 side_reg [1:ST_UX];
    logic signed [PROD_W-1:0]   pab_reg, pba_reg, sqax_reg, sqay_reg, sqbx_reg, sqby_reg;
    logic signed [DET_W-1:0]    det_reg;
    logic        [SQS_W-1:0]    a2_reg, b2_reg;
    logic signed [PPL_W-1:0]    pp_lo_reg [0:3];
    logic signed [PPH_W-1:0]    pp_hi_reg [0:3];
    logic signed [NX_W-1:0]     fp_reg    [0:3];
    logic signed [NX_W-1:0]     n_reg     [0:1];
    logic        [NUM_W-1:0]    nmag_reg  [0:1];
    logic                       nneg_reg  [0:1];
    logic        [ADET_W-1:0]   adet_c;

    logic [NUM_W-1:0]  div_n_reg   [0:1][0:NUM_W];
    logic [DIV_W-1:0]  div_r_reg   [0:1][0:NUM_W];
    logic [DIV_W-1:0]  div_d_reg   [0:1][0:NUM_W];
    logic              div_neg_reg [0:1][0:NUM_W];
    logic [NUM_W-1:0]  div_n_next  [0:1][1:NUM_W];
    logic [DIV_W-1:0]  div_r_next  [0:1][1:NUM_W];
    logic [DIV_W:0]    div_sh      [0:1][1:NUM_W];
    logic [DIV_W:0]    div_df      [0:1][1:NUM_W];

    logic signed [U_W-1:0]   ux_reg  [0:1];
    logic signed [WC_W-1:0]  cw_reg  [0:1];
    logic        [MAG_W-1:0] um_reg  [0:1];
    logic                    f33_reg [0:1];
    logic                    coll1_reg;
    logic signed [U_W-1:0]   ux_chk  [0:1];
    logic signed [WC_W-1:0]  cw_chk  [0:1];
    logic                    f33_c   [0:1];
    logic                    f32_c   [0:1];
    logic signed [CEN_W-1:0] cl_c    [0:1];

    logic [SQ_W-1:0]   sq_reg [0:1];
    tpaf_post_t        post_reg [ST_P2:ST_SQE];
    logic [SQ_W-1:0]   sr_s_reg    [ST_P3:ST_SQE];
    logic [REM_W-1:0]  sr_rem_reg  [ST_P3:ST_SQE];
    logic [ROOT_W-1:0] sr_root_reg [ST_P3:ST_SQE];
    logic [REM_W-1:0]  sr_remx     [ST_P3+1:ST_SQE];
    logic [REM_W-1:0]  sr_trial    [ST_P3+1:ST_SQE];
    logic [REM_W-1:0]  sr_rem_next [ST_P3+1:ST_SQE];
    logic [ROOT_W-1:0] sr_root_next[ST_P3+1:ST_SQE];
    logic [ROOT_W:0]   rnd_c;

    logic signed [VEC_W-1:0] nvx_reg [0:2][ST_P1:ST_NE];
    logic signed [VEC_W-1:0] nvy_reg [0:2][ST_P1:ST_NE];
    logic signed [VEC_W-1:0] nvx_next[0:2][ST_P1+1:ST_NE];
    logic signed [VEC_W-1:0] nvy_next[0:2][ST_P1+1:ST_NE];
    logic signed [VEC_W-1:0] tx_c    [0:2][ST_P1+1:ST_NE];
    logic signed [VEC_W-1:0] ty_c    [0:2][ST_P1+1:ST_NE];
    logic                    zf_reg  [0:2][ST_P1+1:ST_CE];
    logic signed [KEEP_W-1:0] kx_c   [0:2];
    logic signed [KEEP_W-1:0] ky_c   [0:2];
    logic signed [CX_W-1:0]  cx_reg  [0:2][ST_CI:ST_CE];
    logic signed [CX_W-1:0]  cy_reg  [0:2][ST_CI:ST_CE];
    logic        [Z_W-1:0]   cz_reg  [0:2][ST_CI:ST_CE];
    logic signed [CX_W-1:0]  cx_next [0:2][ST_CI+1:ST_CE];
    logic signed [CX_W-1:0]  cy_next [0:2][ST_CI+1:ST_CE];
    logic        [Z_W-1:0]   cz_next [0:2][ST_CI+1:ST_CE];
    logic        [Z_W-1:0]   zr_c    [0:2];
    logic [ANGLE_BITS-1:0]   ang_reg [0:2];
    logic [ANGLE_BITS-1:0]   st_reg  [ST_SEL:ST_SQE];
    logic [ANGLE_BITS-1:0]   en_reg  [ST_SEL:ST_SQE];
    logic                    on_c;

    tpaf_res_t res_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = vld_reg[LAT-1];
    assign result    = res_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // determinant and collinear test
    assign adet_c = det_reg[DET_W-1] ? ADET_W'(-det_reg) : ADET_W'(det_reg);

    always_ff @(posedge clk)
    begin
        side_reg[1] <= '{x0:   request.first_x,
                         y0:   request.first_y,
                         ax:   DIFF_W'(request.mid_x)  - DIFF_W'(request.first_x),
                         ay:   DIFF_W'(request.mid_y)  - DIFF_W'(request.first_y),
                         bx:   DIFF_W'(request.last_x) - DIFF_W'(request.first_x),
                         by:   DIFF_W'(request.last_y) - DIFF_W'(request.first_y),
                         adet: '0,
                         dneg: 1'b0,
                         coll: 1'b0};
        for (int k = 2; k <= ST_UX; k++)
        begin
            if (k != ST_DET)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        side_reg[ST_DET] <= '{x0:   side_reg[ST_DET-1].x0,
                              y0:   side_reg[ST_DET-1].y0,
                              ax:   side_reg[ST_DET-1].ax,
                              ay:   side_reg[ST_DET-1].ay,
                              bx:   side_reg[ST_DET-1].bx,
                              by:   side_reg[ST_DET-1].by,
                              adet: adet_c,
                              dneg: det_reg[DET_W-1],
                              coll: (det_reg == '0) || (adet_c < ADET_W'(thr_reg))};

        pab_reg  <= side_reg[1].ax * side_reg[1].by;
        pba_reg  <= side_reg[1].ay * side_reg[1].bx;
        sqax_reg <= side_reg[1].ax * side_reg[1].ax;
        sqay_reg <= side_reg[1].ay * side_reg[1].ay;
        sqbx_reg <= side_reg[1].bx * side_reg[1].bx;
        sqby_reg <= side_reg[1].by * side_reg[1].by;

        det_reg <= pab_reg - pba_reg;
        a2_reg  <= SQS_W'(sqax_reg + sqay_reg);
        b2_reg  <= SQS_W'(sqbx_reg + sqby_reg);

        // numerators split in partial products
        pp_lo_reg[0] <= side_reg[3].by * $signed({1'b0, a2_reg[LO_W-1:0]});
        pp_hi_reg[0] <= side_reg[3].by * $signed({1'b0, a2_reg[SQS_W-1:LO_W]});
        pp_lo_reg[1] <= side_reg[3].ay * $signed({1'b0, b2_reg[LO_W-1:0]});
        pp_hi_reg[1] <= side_reg[3].ay * $signed({1'b0, b2_reg[SQS_W-1:LO_W]});
        pp_lo_reg[2] <= side_reg[3].ax * $signed({1'b0, b2_reg[LO_W-1:0]});
        pp_hi_reg[2] <= side_reg[3].ax * $signed({1'b0, b2_reg[SQS_W-1:LO_W]});
        pp_lo_reg[3] <= side_reg[3].bx * $signed({1'b0, a2_reg[LO_W-1:0]});
        pp_hi_reg[3] <= side_reg[3].bx * $signed({1'b0, a2_reg[SQS_W-1:LO_W]});

        for (int k = 0; k < 4; k++)
        begin
            fp_reg[k] <= NX_W'(pp_lo_reg[k]) + (NX_W'(pp_hi_reg[k]) <<< LO_W);
        end

        n_reg[0] <= fp_reg[0] - fp_reg[1];
        n_reg[1] <= fp_reg[2] - fp_reg[3];

        for (int l = 0; l < 2; l++)
        begin
            nneg_reg[l] <= n_reg[l][NX_W-1];
            nmag_reg[l] <= n_reg[l][NX_W-1] ? NUM_W'(-n_reg[l]) : NUM_W'(n_reg[l]);
            div_n_reg[l][0]   <= nmag_reg[l] + NUM_W'(side_reg[ST_DIV0-1].adet);
            div_d_reg[l][0]   <= {side_reg[ST_DIV0-1].adet, 1'b0};
            div_r_reg[l][0]   <= '0;
            div_neg_reg[l][0] <= nneg_reg[l] ^ side_reg[ST_DIV0-1].dneg;
            for (int j = 1; j <= NUM_W; j++)
            begin
                div_n_reg[l][j]   <= div_n_next[l][j];
                div_r_reg[l][j]   <= div_r_next[l][j];
                div_d_reg[l][j]   <= div_d_reg[l][j-1];
                div_neg_reg[l][j] <= div_neg_reg[l][j-1];
            end
            ux_reg[l] <= div_neg_reg[l][NUM_W] ? -U_W'(div_n_reg[l][NUM_W])
                                               : U_W'(div_n_reg[l][NUM_W]);
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int j = 1; j <= NUM_W; j++)
            begin
                div_sh[l][j] = {div_r_reg[l][j-1], div_n_reg[l][j-1][NUM_W-1]};
                div_df[l][j] = div_sh[l][j] - {1'b0, div_d_reg[l][j-1]};
                if (!div_df[l][j][DIV_W])
                begin
                    div_r_next[l][j] = div_df[l][j][DIV_W-1:0];
                    div_n_next[l][j] = {div_n_reg[l][j-1][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    div_r_next[l][j] = div_sh[l][j][DIV_W-1:0];
                    div_n_next[l][j] = {div_n_reg[l][j-1][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // centre, range checks and radius squares
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ux_chk[l] = ux_reg[l] >>> CEN_W;
            f33_c[l]  = (&ux_chk[l]) || (~|ux_chk[l]);
            cw_chk[l] = cw_reg[l] >>> (CEN_W - 1);
            f32_c[l]  = (&cw_chk[l]) || (~|cw_chk[l]);
            if (f32_c[l])
            begin
                cl_c[l] = CEN_W'(cw_reg[l]);
            end
            else if (cw_reg[l][WC_W-1])
            begin
                cl_c[l] = {1'b1, {(CEN_W-1){1'b0}}};
            end
            else
            begin
                cl_c[l] = {1'b0, {(CEN_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            f33_reg[l] <= f33_c[l];
            um_reg[l]  <= ux_reg[l][U_W-1] ? MAG_W'(-ux_reg[l]) : MAG_W'(ux_reg[l]);
            sq_reg[l]  <= um_reg[l] * um_reg[l];
        end
        cw_reg[0] <= WC_W'(side_reg[ST_UX].x0) + WC_W'(ux_reg[0]);
        cw_reg[1] <= WC_W'(side_reg[ST_UX].y0) + WC_W'(ux_reg[1]);
        coll1_reg <= side_reg[ST_UX].coll;

        nvx_reg[0][ST_P1] <= -VEC_W'(ux_reg[0]);
        nvy_reg[0][ST_P1] <= -VEC_W'(ux_reg[1]);
        nvx_reg[1][ST_P1] <= VEC_W'(side_reg[ST_UX].ax) - VEC_W'(ux_reg[0]);
        nvy_reg[1][ST_P1] <= VEC_W'(side_reg[ST_UX].ay) - VEC_W'(ux_reg[1]);
        nvx_reg[2][ST_P1] <= VEC_W'(side_reg[ST_UX].bx) - VEC_W'(ux_reg[0]);
        nvy_reg[2][ST_P1] <= VEC_W'(side_reg[ST_UX].by) - VEC_W'(ux_reg[1]);

        post_reg[ST_P2] <= '{cx:   cl_c[0],
                             cy:   cl_c[1],
                             sat:  !f32_c[0] || !f32_c[1],
                             big:  !(f33_reg[0] && f33_reg[1]),
                             coll: coll1_reg};
        for (int k = ST_P2 + 1; k <= ST_SQE; k++)
        begin
            post_reg[k] <= post_reg[k-1];
        end

        sr_s_reg[ST_P3]    <= sq_reg[0] + sq_reg[1];
        sr_rem_reg[ST_P3]  <= '0;
        sr_root_reg[ST_P3] <= '0;
        for (int k = ST_P3 + 1; k <= ST_SQE; k++)
        begin
            sr_s_reg[k]    <= {sr_s_reg[k-1][SQ_W-3:0], 2'b00};
            sr_rem_reg[k]  <= sr_rem_next[k];
            sr_root_reg[k] <= sr_root_next[k];
        end
    end

    // square root, two radicand bits per stage
    always_comb
    begin
        for (int k = ST_P3 + 1; k <= ST_SQE; k++)
        begin
            sr_remx[k]  = {sr_rem_reg[k-1][REM_W-3:0], sr_s_reg[k-1][SQ_W-1 -: 2]};
            sr_trial[k] = REM_W'({sr_root_reg[k-1], 2'b01});
            if (sr_remx[k] >= sr_trial[k])
            begin
                sr_rem_next[k]  = sr_remx[k] - sr_trial[k];
                sr_root_next[k] = {sr_root_reg[k-1][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sr_rem_next[k]  = sr_remx[k];
                sr_root_next[k] = {sr_root_reg[k-1][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // angle lanes: normalise, then cordic vectoring
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = ST_P1 + 1; k <= ST_NE; k++)
            begin
                tx_c[a][k] = nvx_reg[a][k-1] >>> (VEC_W - 1 - (1 << (ST_NE - k)));
                ty_c[a][k] = nvy_reg[a][k-1] >>> (VEC_W - 1 - (1 << (ST_NE - k)));
                if (((&tx_c[a][k]) || (~|tx_c[a][k])) && ((&ty_c[a][k]) || (~|ty_c[a][k])))
                begin
                    nvx_next[a][k] = nvx_reg[a][k-1] <<< (1 << (ST_NE - k));
                    nvy_next[a][k] = nvy_reg[a][k-1] <<< (1 << (ST_NE - k));
                end
                else
                begin
                    nvx_next[a][k] = nvx_reg[a][k-1];
                    nvy_next[a][k] = nvy_reg[a][k-1];
                end
            end
            kx_c[a] = nvx_reg[a][ST_NE][VEC_W-1 -: KEEP_W];
            ky_c[a] = nvy_reg[a][ST_NE][VEC_W-1 -: KEEP_W];
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (cy_reg[a][ST_CI+i] > 0)
                begin
                    cx_next[a][ST_CI+i+1] = cx_reg[a][ST_CI+i] + (cy_reg[a][ST_CI+i] >>> i);
                    cy_next[a][ST_CI+i+1] = cy_reg[a][ST_CI+i] - (cx_reg[a][ST_CI+i] >>> i);
                    cz_next[a][ST_CI+i+1] = cz_reg[a][ST_CI+i] + atan_ang(i);
                end
                else
                begin
                    cx_next[a][ST_CI+i+1] = cx_reg[a][ST_CI+i] - (cy_reg[a][ST_CI+i] >>> i);
                    cy_next[a][ST_CI+i+1] = cy_reg[a][ST_CI+i] + (cx_reg[a][ST_CI+i] >>> i);
                    cz_next[a][ST_CI+i+1] = cz_reg[a][ST_CI+i] - atan_ang(i);
                end
            end
            zr_c[a] = cz_reg[a][ST_CE] + Z_W'(1 << (Z_W - ANGLE_BITS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            zf_reg[a][ST_P1+1] <= (nvx_reg[a][ST_P1] == '0) && (nvy_reg[a][ST_P1] == '0);
            for (int k = ST_P1 + 2; k <= ST_CE; k++)
            begin
                zf_reg[a][k] <= zf_reg[a][k-1];
            end
            for (int k = ST_P1 + 1; k <= ST_NE; k++)
            begin
                nvx_reg[a][k] <= nvx_next[a][k];
                nvy_reg[a][k] <= nvy_next[a][k];
            end
            if (kx_c[a] < 0)
            begin
                cx_reg[a][ST_CI] <= -CX_W'(kx_c[a]);
                cy_reg[a][ST_CI] <= -CX_W'(ky_c[a]);
                cz_reg[a][ST_CI] <= {1'b1, {(Z_W-1){1'b0}}};
            end
            else
            begin
                cx_reg[a][ST_CI] <= CX_W'(kx_c[a]);
                cy_reg[a][ST_CI] <= CX_W'(ky_c[a]);
                cz_reg[a][ST_CI] <= '0;
            end
            for (int k = ST_CI + 1; k <= ST_CE; k++)
            begin
                cx_reg[a][k] <= cx_next[a][k];
                cy_reg[a][k] <= cy_next[a][k];
                cz_reg[a][k] <= cz_next[a][k];
            end
            ang_reg[a] <= zf_reg[a][ST_CE] ? '0 : zr_c[a][Z_W-1 -: ANGLE_BITS];
        end
    end

    // counter-clockwise arc through the middle point
    always_comb
    begin
        if (ang_reg[0] <= ang_reg[2])
        begin
            on_c = (ang_reg[1] >= ang_reg[0]) && (ang_reg[1] <= ang_reg[2]);
        end
        else
        begin
            on_c = (ang_reg[1] >= ang_reg[0]) || (ang_reg[1] <= ang_reg[2]);
        end
    end

    assign rnd_c = {1'b0, sr_root_reg[ST_SQE]}
                 + (ROOT_W + 1)'(sr_rem_reg[ST_SQE] > REM_W'(sr_root_reg[ST_SQE]));

    always_ff @(posedge clk)
    begin
        st_reg[ST_SEL] <= on_c ? ang_reg[0] : ang_reg[2];
        en_reg[ST_SEL] <= on_c ? ang_reg[2] : ang_reg[0];
        for (int k = ST_SEL + 1; k <= ST_SQE; k++)
        begin
            st_reg[k] <= st_reg[k-1];
            en_reg[k] <= en_reg[k-1];
        end

        if (post_reg[ST_SQE].coll)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg.arc_valid   <= 1'b1;
            res_reg.center_x    <= post_reg[ST_SQE].cx;
            res_reg.center_y    <= post_reg[ST_SQE].cy;
            res_reg.start_angle <= st_reg[ST_SQE];
            res_reg.end_angle   <= en_reg[ST_SQE];
            if (post_reg[ST_SQE].big || (rnd_c[ROOT_W:CEN_W] != '0))
            begin
                res_reg.radius    <= '1;
                res_reg.saturated <= 1'b1;
            end
            else
            begin
                res_reg.radius    <= rnd_c[CEN_W-1:0];
                res_reg.saturated <= post_reg[ST_SQE].sat;
            end
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the three point arc fit
//
// point triples are queued by a stimulus process and presented on the command
// port with random gaps; every accepted request is run through an arc
// predictor held in the bench and the expected arc is compared field by field
// with the strobed result. the collinear threshold is rewritten between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

    import tpaf_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam logic [31:0] ARC_TAN [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41721, 32'd20860
    };
    localparam int DRAIN_CYCLES  = 130;
    localparam int STALL_LIMIT   = 5000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    tpaf_req_t         request   = '0;
    logic              done;
    tpaf_res_t         result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [THR_W-1:0]  cfg_data  = '0;

    tpaf_req_t         pending_triples[$];
    tpaf_res_t         arcs_due[$];
    logic [THR_W-1:0]  threshold = 48'd1;
    logic              took      = 1'b0;
    bit                calm      = 1'b0;
    int                errors    = 0;
    int                quiet     = 0;

    three_point_arc_fit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit fits(wide_t a, int bits);
        wide_t lim;
        lim = wide_t'(1) <<< (bits - 1);
        return (a >= -lim) && (a < lim);
    endfunction

    function automatic wide_t round_quot(wide_t n, wide_t d);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (an + ad) / (ad << 1);
        return ((n < 0) != (d < 0)) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic logic [ANGLE_BITS-1:0] polar_angle(wide_t x, wide_t y);
        logic signed [63:0] xi;
        logic signed [63:0] yi;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0]        z;
        int                 k;
        if (x == 0 && y == 0)
            return '0;
        z = '0;
        for (k = 0; k < 128 && !(fits(x, 31) && fits(y, 31)); k++)
        begin
            x = x >>> 1;
            y = y >>> 1;
        end
        for (k = 0; k < 64 && fits(x, 30) && fits(y, 30); k++)
        begin
            x = x <<< 1;
            y = y <<< 1;
        end
        xi = x[63:0];
        yi = y[63:0];
        if (xi < 0)
        begin
            xi = -xi;
            yi = -yi;
            z  = 32'h8000_0000;
        end
        for (k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = yi >>> k;
            dy = xi >>> k;
            if (yi > 0)
            begin
                xi = xi + dx;
                yi = yi - dy;
                z  = z + ARC_TAN[k];
            end
            else
            begin
                xi = xi - dx;
                yi = yi + dy;
                z  = z - ARC_TAN[k];
            end
        end
        z = (z + 32'h0000_8000) >> 16;
        return z[ANGLE_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] clip32(wide_t v, ref bit sat);
        if (fits(v, 32))
            return v[31:0];
        sat = 1'b1;
        return (v < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic tpaf_res_t fit_arc(tpaf_req_t r, logic [THR_W-1:0] thr);
        tpaf_res_t    o;
        wide_t        x0, y0, ax, ay, bx, by, det, adet, a2, b2, nx, ny, ux, uy, s;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] su;
        logic [ANGLE_BITS-1:0] t0, t1, t2;
        bit           sat;
        bit           on;
        int           b;
        o   = '0;
        sat = 1'b0;
        x0 = r.first_x;
        y0 = r.first_y;
        ax = r.mid_x;
        ay = r.mid_y;
        bx = r.last_x;
        by = r.last_y;
        ax = ax - x0;
        ay = ay - y0;
        bx = bx - x0;
        by = by - y0;
        det  = ax * by - ay * bx;
        adet = (det < 0) ? -det : det;
        if (det == 0 || adet < wide_t'({80'b0, thr}))
            return o;
        a2 = ax * ax + ay * ay;
        b2 = bx * bx + by * by;
        nx = by * a2 - ay * b2;
        ny = ax * b2 - bx * a2;
        ux = round_quot(nx, det);
        uy = round_quot(ny, det);
        o.center_x = clip32(x0 + ux, sat);
        o.center_y = clip32(y0 + uy, sat);
        if (fits(ux, 33) && fits(uy, 33))
        begin
            s    = ux * ux + uy * uy;
            su   = s;
            root = '0;
            for (b = 32; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= su)
                    root = cand;
            end
            if (root * root + root < su)
                root = root + 1;
            if (root > 128'hffff_ffff)
            begin
                o.radius = 32'hffff_ffff;
                sat = 1'b1;
            end
            else
                o.radius = root[31:0];
        end
        else
        begin
            o.radius = 32'hffff_ffff;
            sat = 1'b1;
        end
        t0 = polar_angle(-ux, -uy);
        t1 = polar_angle(ax - ux, ay - uy);
        t2 = polar_angle(bx - ux, by - uy);
        if (t0 <= t2)
            on = (t1 >= t0) && (t1 <= t2);
        else
            on = (t1 >= t0) || (t1 <= t2);
        o.arc_valid   = 1'b1;
        o.start_angle = on ? t0 : t2;
        o.end_angle   = on ? t2 : t0;
        o.saturated   = sat;
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp, act);
        end
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 4))
            0:       return 24'h800000;
            1:       return 24'h7fffff;
            2:       return 24'h000000;
            3:       return 24'hffffff;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic tpaf_req_t random_triple();
        tpaf_req_t   r;
        logic signed [23:0] bx, by, dx, dy;
        int          k, j;
        r  = '0;
        bx = 24'($urandom_range(0, 32'h3fffff) - 32'h200000);
        by = 24'($urandom_range(0, 32'h3fffff) - 32'h200000);
        dx = 24'($urandom_range(0, 32'h1ffff) - 32'h10000);
        dy = 24'($urandom_range(0, 32'h1ffff) - 32'h10000);
        k  = int'($urandom_range(1, 4));
        j  = int'($urandom_range(0, 7)) - 3;
        case ($urandom_range(0, 5))
            0:
            begin
                r.first_x = 24'($urandom());
                r.first_y = 24'($urandom());
                r.mid_x   = 24'($urandom());
                r.mid_y   = 24'($urandom());
                r.last_x  = 24'($urandom());
                r.last_y  = 24'($urandom());
            end
            1:
            begin
                r.first_x = 24'(bx + $signed($urandom_range(0, 510)) - 255);
                r.first_y = 24'(by + $signed($urandom_range(0, 510)) - 255);
                r.mid_x   = 24'(bx + $signed($urandom_range(0, 510)) - 255);
                r.mid_y   = 24'(by + $signed($urandom_range(0, 510)) - 255);
                r.last_x  = 24'(bx + $signed($urandom_range(0, 510)) - 255);
                r.last_y  = 24'(by + $signed($urandom_range(0, 510)) - 255);
            end
            2, 3:
            begin
                r.first_x = bx;
                r.first_y = by;
                r.mid_x   = 24'(bx + j * dx);
                r.mid_y   = 24'(by + j * dy);
                r.last_x  = 24'(bx + k * dx);
                r.last_y  = 24'(by + k * dy);
                if ($urandom_range(0, 1))
                begin
                    r.mid_x = 24'(r.mid_x + $signed($urandom_range(0, 6)) - 3);
                    r.mid_y = 24'(r.mid_y + $signed($urandom_range(0, 6)) - 3);
                end
            end
            4:
            begin
                r.first_x = pick_coord();
                r.first_y = pick_coord();
                r.mid_x   = pick_coord();
                r.mid_y   = pick_coord();
                r.last_x  = pick_coord();
                r.last_y  = pick_coord();
            end
            default:
            begin
                r.first_x = bx;
                r.first_y = by;
                r.mid_x   = bx + dx;
                r.mid_y   = by + dy;
                r.last_x  = bx + dy;
                r.last_y  = by - dx;
            end
        endcase
        return r;
    endfunction

    function automatic tpaf_req_t triple(int x0, int y0, int x1, int y1, int x2, int y2);
        tpaf_req_t r;
        r.first_x = 24'(x0);
        r.first_y = 24'(y0);
        r.mid_x   = 24'(x1);
        r.mid_y   = 24'(y1);
        r.last_x  = 24'(x2);
        r.last_y  = 24'(y2);
        return r;
    endfunction

    task automatic queue_triple(tpaf_req_t r);
        pending_triples.insert(pending_triples.size(), r);
    endtask

    task automatic drain();
        while (pending_triples.size() != 0 || start || arcs_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int n);
        repeat (n) queue_triple(random_triple());
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!start || took)
        begin
            if (pending_triples.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                start   <= 1'b1;
                request <= pending_triples.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // request capture, result check and watchdog
    always @(posedge clk)
    begin
        tpaf_res_t exp;
        took <= start && !busy;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (start && !busy)
            begin
                arcs_due.insert(arcs_due.size(), fit_arc(request, threshold));
            end
            if (done)
            begin
                if (arcs_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result: expected none actual %h", $time, result);
                end
                else
                begin
                    exp = arcs_due.pop_front();
                    check_field("arc_valid", exp.arc_valid, result.arc_valid);
                    check_field("center_x", exp.center_x, result.center_x);
                    check_field("center_y", exp.center_y, result.center_y);
                    check_field("radius", exp.radius, result.radius);
                    check_field("start_angle", exp.start_angle, result.start_angle);
                    check_field("end_angle", exp.end_angle, result.end_angle);
                    check_field("saturated", exp.saturated, result.saturated);
                end
            end
            if (quiet >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed triples at the reset threshold
        queue_triple(triple(0, 0, 0, 0, 0, 0));
        queue_triple(triple(0, 0, 256, 0, 0, 256));
        queue_triple(triple(0, 0, 1, 0, 0, 1));
        queue_triple(triple(0, 0, 1, 0, 1, 1));
        queue_triple(triple(0, 0, 0, 1, 1, 0));
        queue_triple(triple(-256, 0, 0, 256, 256, 0));
        queue_triple(triple(256, 0, 0, 256, -256, 0));
        queue_triple(triple(0, 0, 512, 512, 1024, 1024));
        queue_triple(triple(-8388608, -8388608, 8388607, -8388608,
                            8388607, 8388607));
        queue_triple(triple(8388607, 8388607, -8388608, 8388607,
                            -8388608, -8388608));
        queue_triple(triple(-8388608, -8388608, 0, 1, 8388607, 8388607));
        queue_triple(triple(-8388608, 0, 0, 1, 8388607, 0));
        queue_triple(triple(-8388608, -8388608, -8388607, -8388608,
                            -8388608, -8388607));
        queue_triple(triple(8388607, 0, 0, 8388607, -8388608, 0));
        queue_triple(triple(0, -8388608, 8388607, 0, 0, 8388607));
        queue_triple(triple(100, 100, 100, 100, 300, 50));
        queue_triple(triple(-1, -1, -1, -1, -1, -1));
        queue_triple(triple(0, 0, 2, 1, 4, 3));
        drain();

        write_threshold(48'd0);
        queue_random(110);
        drain();

        write_threshold(48'hffff_ffff_ffff);
        queue_random(80);
        drain();

        write_threshold(48'd1 << $urandom_range(0, 47));
        queue_random(110);
        drain();

        // long stretch without gaps
        write_threshold(48'd1);
        calm = 1'b1;
        queue_random(70);
        drain();
        calm = 1'b0;
        queue_random(60);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
